FILE: rtl/dsil_pkg.sv
// shared constants and types for the distance sorted insert list
`default_nettype none

package dsil_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 32;

  localparam int KEY_W  = 32;
  localparam int PORT_TAG_W = 32;
  // stored tag bits, the port carries no more than 32
  localparam int TAG_W  = (TAG_BITS < PORT_TAG_W) ? TAG_BITS : PORT_TAG_W;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int RIDX_W = 4;
  localparam int RD_W   = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam int OCNT_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // insert control broadcast to every cell
  typedef struct packed {
    logic   insert_en;
    entry_t new_entry;
  } ins_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/dsil_cell.sv
// one list slot: compares the new key and takes new, left or own entry
`default_nettype none

module dsil_cell (
  input  wire logic               clk,
  input  wire dsil_pkg::ins_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire logic               left_ins,
  input  wire dsil_pkg::entry_t   left_entry,
  output logic                    ins,
  output dsil_pkg::entry_t        entry
);

  dsil_pkg::entry_t entry_next;

  // an empty slot counts as larger than any new key
  assign ins = !occupied || (ctrl.new_entry.key <= entry.key);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert_en && ins) begin
      if (left_ins) begin
        entry_next = left_entry;
      end else begin
        entry_next = ctrl.new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

FILE: rtl/dsil_read_sel.sv
// rank lookup across the cell row with range check against the count
`default_nettype none

module dsil_read_sel (
  input  wire dsil_pkg::entry_t [dsil_pkg::DEPTH-1:0] entries,
  input  wire logic [dsil_pkg::RIDX_W-1:0]            read_index,
  input  wire logic [dsil_pkg::CNT_W-1:0]             count,
  output dsil_pkg::entry_t                            sel_entry,
  output logic                                        index_ok
);

  logic [dsil_pkg::RD_W-1:0] ridx_ext;

  assign ridx_ext = dsil_pkg::RD_W'(read_index);
  assign index_ok = ridx_ext < dsil_pkg::RD_W'(count);

  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < dsil_pkg::DEPTH; i++) begin
      if (index_ok && (ridx_ext == dsil_pkg::RD_W'(i))) begin
        sel_entry = entries[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/distance_sorted_insert_list.sv
// top level: row of sorted list cells, fill count and registered result
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   input    | in_valid / in_stall | cmd, new_distance, new_tag, read_index
//   output   | out_valid/out_stall | out_distance, out_tag, entry_count,
//            |                     | index_ok, overflow
//
// one transaction per cycle while in_stall is low: every cell compares the new
// key at once and shifts right in the same edge that accepts the transaction.
// the result sits in an output register; a new transaction is taken whenever
// that register is empty or being drained.
// rst clears the count and the output valid; cell contents are not cleared.
`default_nettype none

module distance_sorted_insert_list (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            cmd,
  input  wire logic [dsil_pkg::KEY_W-1:0]      new_distance,
  input  wire logic [dsil_pkg::PORT_TAG_W-1:0] new_tag,
  input  wire logic [dsil_pkg::RIDX_W-1:0]     read_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [dsil_pkg::KEY_W-1:0]           out_distance,
  output logic [dsil_pkg::PORT_TAG_W-1:0]      out_tag,
  output logic [dsil_pkg::OCNT_W-1:0]          entry_count,
  output logic                                 index_ok,
  output logic                                 overflow
);

  logic                                    accept;
  logic                                    is_insert;
  logic                                    full;
  logic [dsil_pkg::CNT_W-1:0]              count;
  logic [dsil_pkg::CNT_W-1:0]              count_next;
  dsil_pkg::ins_ctrl_t                     ctrl;
  dsil_pkg::entry_t [dsil_pkg::DEPTH-1:0]  entries;
  logic [dsil_pkg::DEPTH-1:0]              ins;
  dsil_pkg::entry_t                        sel_entry;
  logic                                    sel_ok;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign is_insert = (cmd == dsil_pkg::CMD_INSERT);
  assign full      = (count == dsil_pkg::CNT_W'(dsil_pkg::DEPTH));

  assign ctrl.insert_en     = accept && is_insert;
  assign ctrl.new_entry.key = new_distance;
  assign ctrl.new_entry.tag = new_tag[dsil_pkg::TAG_W-1:0];

  always_comb begin
    count_next = count;
    if (ctrl.insert_en && !full) begin
      count_next = count + 1'b1;
    end
  end

  genvar g;
  generate
    for (g = 0; g < dsil_pkg::DEPTH; g++) begin : g_cell
      logic             occ;
      logic             l_ins;
      dsil_pkg::entry_t l_entry;

      assign occ = dsil_pkg::CNT_W'(g) < count;

      if (g == 0) begin : g_head
        assign l_ins   = 1'b0;
        assign l_entry = ctrl.new_entry;
      end else begin : g_body
        assign l_ins   = ins[g-1];
        assign l_entry = entries[g-1];
      end

      dsil_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ),
        .left_ins   (l_ins),
        .left_entry (l_entry),
        .ins        (ins[g]),
        .entry      (entries[g])
      );
    end
  endgenerate

  dsil_read_sel u_read_sel (
    .entries    (entries),
    .read_index (read_index),
    .count      (count),
    .sel_entry  (sel_entry),
    .index_ok   (sel_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      entry_count <= dsil_pkg::OCNT_W'(count_next);
      if (is_insert) begin
        out_distance <= '0;
        out_tag      <= '0;
        index_ok     <= 1'b1;
        overflow     <= full;
      end else begin
        out_distance <= sel_entry.key;
        out_tag      <= dsil_pkg::PORT_TAG_W'(sel_entry.tag);
        index_ok     <= sel_ok;
        overflow     <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/dsil_checker.sv
// checker for the distance sorted insert list: mirrors the list and compares every result
`timescale 1ns / 1ps

module dsil_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire logic                            cmd,
  input  wire logic [dsil_pkg::KEY_W-1:0]      new_distance,
  input  wire logic [dsil_pkg::PORT_TAG_W-1:0] new_tag,
  input  wire logic [dsil_pkg::RIDX_W-1:0]     read_index,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic [dsil_pkg::KEY_W-1:0]      out_distance,
  input  wire logic [dsil_pkg::PORT_TAG_W-1:0] out_tag,
  input  wire logic [dsil_pkg::OCNT_W-1:0]     entry_count,
  input  wire logic                            index_ok,
  input  wire logic                            overflow,
  output int                                   fail_count,
  output int                                   outstanding
);

  typedef struct packed {
    logic [dsil_pkg::KEY_W-1:0]      dist_val;
    logic [dsil_pkg::PORT_TAG_W-1:0] tag;
    logic [dsil_pkg::OCNT_W-1:0]     count;
    logic                            ok;
    logic                            ovf;
  } list_result_t;

  // mirror of the stored list, nearest first
  logic [dsil_pkg::KEY_W-1:0] mirror_keys [dsil_pkg::DEPTH];
  logic [dsil_pkg::TAG_W-1:0] mirror_tags [dsil_pkg::DEPTH];
  int                         mirror_fill;

  list_result_t step_outcomes [$];
  int           misses = 0;

  function automatic list_result_t insert_or_read(logic op,
                                                  logic [dsil_pkg::KEY_W-1:0] key_val,
                                                  logic [dsil_pkg::PORT_TAG_W-1:0] tag,
                                                  logic [dsil_pkg::RIDX_W-1:0] idx);
    list_result_t r;
    int           slot;
    int           last;
    bit           found;
    r     = '0;
    r.ok  = 1'b1;
    slot  = mirror_fill;
    found = 1'b0;
    if (op == dsil_pkg::CMD_INSERT) begin
      // ties go ahead of the older entry
      for (int i = 0; i < mirror_fill; i++) begin
        if (!found && key_val <= mirror_keys[i]) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (mirror_fill == dsil_pkg::DEPTH) r.ovf = 1'b1;
      // on a full list the last slot falls off, or the new entry if it would go last
      if (slot < dsil_pkg::DEPTH) begin
        last = (mirror_fill == dsil_pkg::DEPTH) ? dsil_pkg::DEPTH - 1 : mirror_fill;
        for (int i = last; i > slot; i--) begin
          mirror_keys[i] = mirror_keys[i-1];
          mirror_tags[i] = mirror_tags[i-1];
        end
        mirror_keys[slot] = key_val;
        mirror_tags[slot] = tag[dsil_pkg::TAG_W-1:0];
      end
      if (mirror_fill < dsil_pkg::DEPTH) mirror_fill++;
    end else if (idx < mirror_fill) begin
      r.dist_val = mirror_keys[idx];
      r.tag      = mirror_tags[idx];
    end else begin
      r.ok = 1'b0;
    end
    r.count = dsil_pkg::OCNT_W'(mirror_fill);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    misses++;
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      mirror_fill = 0;
      step_outcomes.delete();
    end else begin
      // a result always comes from an earlier transaction, so retire before adding
      if (out_valid && !out_stall) begin
        if (step_outcomes.size() == 0) begin
          flag_mismatch("result with nothing awaited, distance", out_distance, 32'd0);
        end else begin
          want = step_outcomes.pop_front();
          if (out_distance !== want.dist_val)
            flag_mismatch("out_distance", out_distance, want.dist_val);
          if (out_tag !== want.tag) flag_mismatch("out_tag", out_tag, want.tag);
          if (entry_count !== want.count)
            flag_mismatch("entry_count", 32'(entry_count), 32'(want.count));
          if (index_ok !== want.ok) flag_mismatch("index_ok", 32'(index_ok), 32'(want.ok));
          if (overflow !== want.ovf) flag_mismatch("overflow", 32'(overflow), 32'(want.ovf));
        end
      end
      if (in_valid && !in_stall)
        step_outcomes = {step_outcomes,
                         insert_or_read(cmd, new_distance, new_tag, read_index)};
    end
    outstanding <= step_outcomes.size();
    fail_count  <= misses;
  end

endmodule

FILE: tb/sv/testbench.sv
// top of the distance sorted insert list test: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 1625;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic                            cmd;
  logic [dsil_pkg::KEY_W-1:0]      new_distance;
  logic [dsil_pkg::PORT_TAG_W-1:0] new_tag;
  logic [dsil_pkg::RIDX_W-1:0]     read_index;
  logic                            out_valid;
  logic                            out_stall;
  logic [dsil_pkg::KEY_W-1:0]      out_distance;
  logic [dsil_pkg::PORT_TAG_W-1:0] out_tag;
  logic [dsil_pkg::OCNT_W-1:0]     entry_count;
  logic                            index_ok;
  logic                            overflow;
  int                              fail_count;
  int                              outstanding;

  logic [dsil_pkg::KEY_W-1:0] recent_keys [8];
  int                         recent_ptr;
  int                         insert_total;

  always #5 clk = ~clk;

  distance_sorted_insert_list u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .new_distance (new_distance),
    .new_tag      (new_tag),
    .read_index   (read_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_distance (out_distance),
    .out_tag      (out_tag),
    .entry_count  (entry_count),
    .index_ok     (index_ok),
    .overflow     (overflow)
  );

  dsil_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .new_distance (new_distance),
    .new_tag      (new_tag),
    .read_index   (read_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_distance (out_distance),
    .out_tag      (out_tag),
    .entry_count  (entry_count),
    .index_ok     (index_ok),
    .overflow     (overflow),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // present one transaction and hold it until the list takes it
  task automatic send_request(input logic op, input logic [dsil_pkg::KEY_W-1:0] key_val,
                              input logic [dsil_pkg::PORT_TAG_W-1:0] tag,
                              input logic [dsil_pkg::RIDX_W-1:0] idx);
    @(negedge clk);
    in_valid     <= 1'b1;
    cmd          <= op;
    new_distance <= key_val;
    new_tag      <= tag;
    read_index   <= idx;
    do @(posedge clk); while (in_stall);
    if (op == dsil_pkg::CMD_INSERT) begin
      recent_keys[recent_ptr] = key_val;
      recent_ptr = (recent_ptr + 1) % 8;
      insert_total++;
    end
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // the list only keeps the smallest keys, so the random window shrinks over the run
  function automatic logic [dsil_pkg::KEY_W-1:0] pick_distance();
    int                         sel;
    logic [dsil_pkg::KEY_W-1:0] win;
    sel = $urandom_range(0, 99);
    win = 32'hFFFF_FFFF >> (insert_total / 64);
    if (sel < 1) return '0;
    if (sel < 4) return '1;
    if (sel < 20) return recent_keys[$urandom_range(0, 7)];
    return $urandom_range(0, win);
  endfunction

  initial begin : stall_pattern
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall <= ~out_stall;
          end
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    int  left;
    int  burst;
    bit  paused;
    logic op;
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = dsil_pkg::CMD_INSERT;
    new_distance = '0;
    new_tag      = '0;
    read_index   = '0;
    recent_ptr   = 0;
    insert_total = 0;
    for (int i = 0; i < 8; i++) recent_keys[i] = 32'd1000 * i;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list reads, extremes and ties at both ends
    send_request(dsil_pkg::CMD_READ, '1, '1, 4'd0);
    send_request(dsil_pkg::CMD_READ, '0, '0, 4'd15);
    send_request(dsil_pkg::CMD_INSERT, '1, '1, 4'd15);
    send_request(dsil_pkg::CMD_INSERT, '0, '0, 4'd0);
    send_request(dsil_pkg::CMD_INSERT, '1, 32'h0000_1234, 4'd7);
    send_request(dsil_pkg::CMD_INSERT, '0, 32'h0000_0005, 4'd3);
    for (int i = 0; i <= 4; i++) send_request(dsil_pkg::CMD_READ, $urandom, $urandom, 4'(i));
    // fill up, then one insert into a full list
    for (int i = 1; i <= 12; i++)
      send_request(dsil_pkg::CMD_INSERT, 32'd100 * i, $urandom, 4'(i));
    send_request(dsil_pkg::CMD_INSERT, 32'd150, $urandom, 4'd0);
    send_request(dsil_pkg::CMD_READ, $urandom, $urandom, 4'd15);

    left   = RANDOM_ITEMS;
    paused = 1'b0;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && left > 0) begin
        op = ($urandom_range(0, 1) != 0) ? dsil_pkg::CMD_READ : dsil_pkg::CMD_INSERT;
        if (op == dsil_pkg::CMD_INSERT)
          send_request(op, pick_distance(), $urandom, 4'($urandom_range(0, 15)));
        else
          send_request(op, $urandom, $urandom, 4'($urandom_range(0, 15)));
        left--;
        burst--;
        // once mid run, let every outstanding result drain completely
        if (!paused && left == RANDOM_ITEMS / 2) begin
          hold_off(1);
          while (outstanding != 0) @(posedge clk);
          paused = 1'b1;
        end
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
    end

    hold_off(1);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
